[design/ofpq_pkg.sv]
`default_nettype none
package ofpq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int TYPE_W   = 3;
  localparam int KIND_W   = 3;
  localparam int HELD_W   = 7;

  // Request codes.
  localparam logic [TYPE_W-1:0] REQ_PUSH     = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_WALK     = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_KEEP     = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_CONTINUE = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_REMOVE   = 3'd4;

  // Result codes.
  localparam logic [KIND_W-1:0] KIND_PUSHED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OFFER  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FOUND  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NOWALK = 3'd5;

  typedef struct packed {
    logic load;  // capture the accepted request
    logic exec;  // carry out the captured request and load the result
  } cmd_t;

endpackage
`default_nettype wire

[design/ofpq_if.sv]
`default_nettype none
interface ofpq_req_if;
  logic                               valid;
  logic                               ready;
  logic [ofpq_pkg::TYPE_W-1:0]        req_type;
  logic [ofpq_pkg::DATA_W-1:0]        payload;
  logic [ofpq_pkg::DATA_W-1:0]        order_key;

  modport source (output valid, req_type, payload, order_key, input ready);
  modport sink   (input valid, req_type, payload, order_key, output ready);
endinterface

interface ofpq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [ofpq_pkg::KIND_W-1:0]        kind;
  logic [ofpq_pkg::DATA_W-1:0]        offered_payload;
  logic [ofpq_pkg::DATA_W-1:0]        offered_order;
  logic [ofpq_pkg::HELD_W-1:0]        held_count;

  modport source (output valid, kind, offered_payload, offered_order, held_count,
                  input ready);
  modport sink   (input valid, kind, offered_payload, offered_order, held_count,
                  output ready);
endinterface
`default_nettype wire

[design/ordered_fifo_priority_queue.sv]
// Flow: an accepted request is captured in the request registers and then
// executed into the result register, which raises the result valid.
// A new request is accepted only after the previous one is executed; the cell chain
// compares, shifts and loads the result register in the execute state after capture.
// A result waiting at the output stalls execution but not capture of the next request.
// Reset: control, fill count and walk state clear asynchronously; the queue is
// empty at once, and cell contents are left as they are.
`default_nettype none
module ordered_fifo_priority_queue (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ofpq_req_if.sink     req_i,
  ofpq_rsp_if.source   rsp_o
);

  ofpq_pkg::cmd_t cmd;

  ofpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  ofpq_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .req_type_i        (req_i.req_type),
    .payload_i         (req_i.payload),
    .order_key_i       (req_i.order_key),
    .kind_o            (rsp_o.kind),
    .offered_payload_o (rsp_o.offered_payload),
    .offered_order_o   (rsp_o.offered_order),
    .held_count_o      (rsp_o.held_count)
  );

endmodule
`default_nettype wire

[design/ofpq_ctrl.sv]
`default_nettype none
module ofpq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ofpq_pkg::cmd_t     cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   exec;

  assign in_ready_o = (state_q == S_IDLE);
  // The result register must be free, or freed in this cycle, before execution.
  assign exec       = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign cmd_o.load = in_valid_i && in_ready_o;
  assign cmd_o.exec = exec;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (out_ready_i) out_valid_q <= 1'b0;
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (exec) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[design/ofpq_dp.sv]
`default_nettype none
module ofpq_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ofpq_pkg::cmd_t                cmd_i,
  input  wire logic [ofpq_pkg::TYPE_W-1:0]   req_type_i,
  input  wire logic [ofpq_pkg::DATA_W-1:0]   payload_i,
  input  wire logic [ofpq_pkg::DATA_W-1:0]   order_key_i,
  output logic [ofpq_pkg::KIND_W-1:0]        kind_o,
  output logic [ofpq_pkg::DATA_W-1:0]        offered_payload_o,
  output logic [ofpq_pkg::DATA_W-1:0]        offered_order_o,
  output logic [ofpq_pkg::HELD_W-1:0]        held_count_o
);

  localparam int N = ofpq_pkg::CAPACITY;

  // Captured request.
  logic [ofpq_pkg::TYPE_W-1:0] req_type_q;
  logic [ofpq_pkg::DATA_W-1:0] pay_q;
  logic [ofpq_pkg::DATA_W-1:0] key_q;

  // Sorted cell chain; the valid cells are always the prefix below count_q.
  logic [ofpq_pkg::DATA_W-1:0] slot_pay_q [N];
  logic [ofpq_pkg::DATA_W-1:0] slot_ord_q [N];
  logic [ofpq_pkg::DATA_W-1:0] slot_pay_d [N];
  logic [ofpq_pkg::DATA_W-1:0] slot_ord_d [N];

  logic [ofpq_pkg::CNT_W-1:0]  count_q, count_d;
  logic [ofpq_pkg::IDX_W-1:0]  cursor_q, cursor_d;
  logic                        open_q, open_d;

  logic [ofpq_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [ofpq_pkg::DATA_W-1:0] opay_q, opay_d;
  logic [ofpq_pkg::DATA_W-1:0] oord_q, oord_d;
  logic [ofpq_pkg::HELD_W-1:0] held_q;

  logic [N-1:0]                le;
  logic                        do_push, do_remove, full, walk_ok;
  logic [ofpq_pkg::CNT_W-1:0]  next_cur;
  logic [ofpq_pkg::IDX_W-1:0]  next_idx;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      le[i] = (ofpq_pkg::CNT_W'(i) < count_q) && (slot_ord_q[i] <= key_q);
    end
  end

  assign full     = (count_q == ofpq_pkg::CNT_W'(N));
  assign walk_ok  = open_q && (ofpq_pkg::CNT_W'(cursor_q) < count_q);
  assign next_cur = ofpq_pkg::CNT_W'(cursor_q) + ofpq_pkg::CNT_W'(1);
  assign next_idx = ofpq_pkg::IDX_W'(next_cur);

  always_comb begin
    count_d   = count_q;
    cursor_d  = cursor_q;
    open_d    = open_q;
    kind_d    = ofpq_pkg::KIND_NOWALK;
    opay_d    = '0;
    oord_d    = '0;
    do_push   = 1'b0;
    do_remove = 1'b0;
    case (req_type_q)
      ofpq_pkg::REQ_PUSH: begin
        open_d   = 1'b0;
        cursor_d = '0;
        if (full) begin
          kind_d = ofpq_pkg::KIND_FULL;
        end else begin
          do_push = 1'b1;
          count_d = count_q + ofpq_pkg::CNT_W'(1);
          kind_d  = ofpq_pkg::KIND_PUSHED;
        end
      end
      ofpq_pkg::REQ_WALK: begin
        cursor_d = '0;
        if (count_q != '0) begin
          open_d = 1'b1;
          kind_d = ofpq_pkg::KIND_OFFER;
          opay_d = slot_pay_q[0];
          oord_d = slot_ord_q[0];
        end else begin
          open_d = 1'b0;
          kind_d = ofpq_pkg::KIND_NONE;
        end
      end
      ofpq_pkg::REQ_KEEP, ofpq_pkg::REQ_CONTINUE, ofpq_pkg::REQ_REMOVE: begin
        open_d   = 1'b0;
        cursor_d = '0;
        if (!walk_ok) begin
          kind_d = ofpq_pkg::KIND_NOWALK;
        end else if (req_type_q == ofpq_pkg::REQ_CONTINUE) begin
          if (next_cur < count_q) begin
            open_d   = 1'b1;
            cursor_d = next_idx;
            kind_d   = ofpq_pkg::KIND_OFFER;
            opay_d   = slot_pay_q[next_idx];
            oord_d   = slot_ord_q[next_idx];
          end else begin
            kind_d = ofpq_pkg::KIND_NONE;
          end
        end else begin
          do_remove = (req_type_q == ofpq_pkg::REQ_REMOVE);
          if (do_remove) count_d = count_q - ofpq_pkg::CNT_W'(1);
          kind_d = ofpq_pkg::KIND_FOUND;
        end
      end
      default: begin
        kind_d = ofpq_pkg::KIND_NOWALK;
      end
    endcase
  end

  // Push: cells at or above the insert point move up by one and the new entry
  // lands at the first cell whose key is greater, or the first free cell. Remove:
  // cells above the cursor move down by one.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      slot_pay_d[i] = slot_pay_q[i];
      slot_ord_d[i] = slot_ord_q[i];
      if (do_push && !le[i]) begin
        if (i == 0) begin
          slot_pay_d[i] = pay_q;
          slot_ord_d[i] = key_q;
        end else if (le[(i == 0) ? 0 : i - 1]) begin
          slot_pay_d[i] = pay_q;
          slot_ord_d[i] = key_q;
        end else begin
          slot_pay_d[i] = slot_pay_q[(i == 0) ? 0 : i - 1];
          slot_ord_d[i] = slot_ord_q[(i == 0) ? 0 : i - 1];
        end
      end else if (do_remove && (i < N - 1) && (ofpq_pkg::IDX_W'(i) >= cursor_q)) begin
        slot_pay_d[i] = slot_pay_q[(i < N - 1) ? i + 1 : i];
        slot_ord_d[i] = slot_ord_q[(i < N - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= req_type_i;
      pay_q      <= payload_i;
      key_q      <= order_key_i;
    end
    if (cmd_i.exec) begin
      for (int i = 0; i < N; i++) begin
        slot_pay_q[i] <= slot_pay_d[i];
        slot_ord_q[i] <= slot_ord_d[i];
      end
      kind_q <= kind_d;
      opay_q <= opay_d;
      oord_q <= oord_d;
      held_q <= ofpq_pkg::HELD_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      open_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      open_q   <= open_d;
    end
  end

  assign kind_o            = kind_q;
  assign offered_payload_o = opay_q;
  assign offered_order_o   = oord_q;
  assign held_count_o      = held_q;

endmodule
`default_nettype wire

[bench/ordered_fifo_priority_queue_tb.sv]
module ordered_fifo_priority_queue_tb;
  import ofpq_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned CALM_TAIL      = 80;

  typedef struct packed {
    logic              pause;  // not a request: wait until every result is back
    logic [TYPE_W-1:0] req_type;
    logic [DATA_W-1:0] payload;
    logic [DATA_W-1:0] order_key;
  } pq_request_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] pay;
    logic [DATA_W-1:0] order;
    logic [HELD_W-1:0] held;
  } pq_result_t;

  logic clk_i;
  logic rst_ni;

  ofpq_req_if req_bus ();
  ofpq_rsp_if rsp_bus ();

  ordered_fifo_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  pq_request_t pending_reqs[$];
  pq_result_t  expected_results[$];
  pq_request_t next_req;
  pq_result_t  got_result;
  pq_result_t  want_result;

  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned long_hold;
  int unsigned stall_cycles;
  int unsigned plan_held;

  // Shadow copy of the queue contents and walk state.
  logic [DATA_W-1:0] shadow_pay[CAPACITY];
  logic [DATA_W-1:0] shadow_key[CAPACITY];
  int unsigned       shadow_held;
  logic              walk_open;
  int unsigned       walk_cursor;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic pq_result_t offer_at_cursor();
    pq_result_t r;
    r = '0;
    if (walk_cursor < shadow_held) begin
      r.kind  = KIND_OFFER;
      r.pay   = shadow_pay[walk_cursor];
      r.order = shadow_key[walk_cursor];
    end else begin
      walk_open   = 1'b0;
      walk_cursor = 0;
      r.kind      = KIND_NONE;
    end
    return r;
  endfunction

  function automatic pq_result_t queue_step(input logic [TYPE_W-1:0] rtype,
                                            input logic [DATA_W-1:0] pay,
                                            input logic [DATA_W-1:0] key);
    pq_result_t  r;
    int unsigned pos;
    int unsigned idx;
    r = '0;
    case (rtype)
      REQ_PUSH: begin
        walk_open   = 1'b0;
        walk_cursor = 0;
        if (shadow_held >= CAPACITY) begin
          r.kind = KIND_FULL;
        end else begin
          // Insert behind every entry with a lower or equal key.
          pos = 0;
          while (pos < shadow_held && shadow_key[pos] <= key) pos++;
          for (idx = shadow_held; idx > pos; idx--) begin
            shadow_pay[idx] = shadow_pay[idx-1];
            shadow_key[idx] = shadow_key[idx-1];
          end
          shadow_pay[pos] = pay;
          shadow_key[pos] = key;
          shadow_held++;
          r.kind = KIND_PUSHED;
        end
      end
      REQ_WALK: begin
        walk_open   = 1'b1;
        walk_cursor = 0;
        r = offer_at_cursor();
      end
      REQ_KEEP, REQ_CONTINUE, REQ_REMOVE: begin
        if (!walk_open || walk_cursor >= shadow_held) begin
          walk_open   = 1'b0;
          walk_cursor = 0;
          r.kind      = KIND_NOWALK;
        end else if (rtype == REQ_CONTINUE) begin
          walk_cursor++;
          r = offer_at_cursor();
        end else begin
          if (rtype == REQ_REMOVE) begin
            for (idx = walk_cursor; idx + 1 < shadow_held; idx++) begin
              shadow_pay[idx] = shadow_pay[idx+1];
              shadow_key[idx] = shadow_key[idx+1];
            end
            shadow_held--;
          end
          walk_open   = 1'b0;
          walk_cursor = 0;
          r.kind      = KIND_FOUND;
        end
      end
      default: r.kind = KIND_NOWALK;
    endcase
    r.held = shadow_held[HELD_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_count < 50) $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic add_req(input logic [TYPE_W-1:0] rtype, input logic [DATA_W-1:0] pay,
                         input logic [DATA_W-1:0] key);
    pq_request_t it;
    it.pause     = 1'b0;
    it.req_type  = rtype;
    it.payload   = pay;
    it.order_key = key;
    pending_reqs.push_back(it);
  endtask

  task automatic add_pause();
    pq_request_t it;
    it       = '0;
    it.pause = 1'b1;
    pending_reqs.push_back(it);
  endtask

  task automatic add_push(input logic [DATA_W-1:0] pay, input logic [DATA_W-1:0] key);
    add_req(REQ_PUSH, pay, key);
    if (plan_held < CAPACITY) plan_held++;
  endtask

  // A walk that is offered the entry at index steps and then gets the reply.
  // When steps reaches the fill level the walk runs out and no reply is sent.
  task automatic add_walk(input int unsigned steps, input logic [TYPE_W-1:0] reply);
    add_req(REQ_WALK, $urandom, $urandom);
    if ($urandom_range(0, 9) == 0) add_req(3'($urandom_range(5, 7)), $urandom, $urandom);
    repeat (steps) add_req(REQ_CONTINUE, $urandom, $urandom);
    if (steps < plan_held) begin
      add_req(reply, $urandom, $urandom);
      if (reply == REQ_REMOVE) plan_held--;
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_key();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    // Small keys make equal keys common, so arrival order within a key is exercised.
    if (mode < 4) return DATA_W'($urandom_range(0, 7));
    if (mode == 4) return '0;
    if (mode == 5) return '1;
    return $urandom;
  endfunction

  // Request side: drives the next pending transaction and predicts each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid     <= 1'b0;
      req_bus.req_type  <= REQ_PUSH;
      req_bus.payload   <= '0;
      req_bus.order_key <= '0;
      src_gap           <= 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        expected_results.push_back(queue_step(req_bus.req_type, req_bus.payload,
                                              req_bus.order_key));
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (src_gap != 0) begin
          src_gap       <= src_gap - 1;
          req_bus.valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          req_bus.valid <= 1'b0;
        end else if (pending_reqs[0].pause) begin
          req_bus.valid <= 1'b0;
          if (!req_bus.valid && expected_results.size() == 0) void'(pending_reqs.pop_front());
        end else begin
          next_req = pending_reqs.pop_front();
          req_bus.valid     <= 1'b1;
          req_bus.req_type  <= next_req.req_type;
          req_bus.payload   <= next_req.payload;
          req_bus.order_key <= next_req.order_key;
          if (pending_reqs.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
            src_gap <= $urandom_range(1, 6);
        end
      end
    end
  end

  // Result side: checks each transaction against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      sink_gap      <= 0;
      long_hold     <= 0;
      results_seen  <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        results_seen <= results_seen + 1;
        got_result.kind  = rsp_bus.kind;
        got_result.pay   = rsp_bus.offered_payload;
        got_result.order = rsp_bus.offered_order;
        got_result.held  = rsp_bus.held_count;
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("result kind %0d with none expected", got_result.kind));
        end else begin
          want_result = expected_results.pop_front();
          if (got_result.kind != want_result.kind)
            note_mismatch($sformatf("kind %0d, expected %0d", got_result.kind,
                                    want_result.kind));
          if (got_result.pay != want_result.pay)
            note_mismatch($sformatf("offered_payload %h, expected %h", got_result.pay,
                                    want_result.pay));
          if (got_result.order != want_result.order)
            note_mismatch($sformatf("offered_order %h, expected %h", got_result.order,
                                    want_result.order));
          if (got_result.held != want_result.held)
            note_mismatch($sformatf("held_count %0d, expected %0d", got_result.held,
                                    want_result.held));
        end
      end
      if (long_hold != 0) begin
        long_hold     <= long_hold - 1;
        rsp_bus.ready <= 1'b0;
      end else if (rsp_bus.valid && rsp_bus.ready &&
                   (results_seen == 200 || results_seen == 300)) begin
        // Hold off long enough for the block to back up and stall its input.
        long_hold     <= 50;
        rsp_bus.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap      <= sink_gap - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
        if (pending_reqs.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
          sink_gap <= $urandom_range(1, 6);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned sel;
    int unsigned steps;
    logic        filled;
    rst_ni            = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.req_type  = REQ_PUSH;
    req_bus.payload   = '0;
    req_bus.order_key = '0;
    rsp_bus.ready     = 1'b0;
    mismatch_count    = 0;
    stall_cycles      = 0;
    shadow_held       = 0;
    walk_open         = 1'b0;
    walk_cursor       = 0;
    plan_held         = 0;
    filled            = 1'b0;

    // Directed part: empty queue, replies without a walk, unknown codes, then pushes, some with equal keys.
    add_req(REQ_WALK, '0, '0);
    add_req(REQ_KEEP, '1, '1);
    add_req(REQ_REMOVE, '0, '0);
    add_req(3'd5, '1, '1);
    add_req(3'd7, '0, '0);
    add_push('0, '1);
    add_push('1, '0);
    add_push(32'h11, 32'd5);
    add_push(32'h12, 32'd5);
    add_push(32'h13, '0);
    // An unknown code in the middle of a walk leaves the walk open.
    add_req(REQ_WALK, '0, '0);
    add_req(3'd6, '1, '1);
    add_req(REQ_CONTINUE, '0, '0);
    add_req(REQ_CONTINUE, '0, '0);
    add_req(REQ_KEEP, '0, '0);
    add_req(REQ_WALK, '0, '0);
    add_req(REQ_CONTINUE, '0, '0);
    add_req(REQ_REMOVE, '0, '0);
    // A push abandons the open walk, so the reply after it finds no walk.
    add_req(REQ_WALK, '0, '0);
    add_push(32'h14, 32'd5);
    add_req(REQ_KEEP, '0, '0);
    // A second walk restarts at the head and then runs past the last entry.
    add_req(REQ_WALK, '0, '0);
    add_req(REQ_CONTINUE, '0, '0);
    add_req(REQ_WALK, '0, '0);
    repeat (5) add_req(REQ_CONTINUE, '0, '0);
    add_req(REQ_CONTINUE, '0, '0);
    plan_held = 5;
    add_pause();

    while (pending_reqs.size() < 560) begin
      sel = $urandom_range(0, 99);
      if (!filled && pending_reqs.size() > 180) begin
        filled = 1'b1;
        while (plan_held < CAPACITY) add_push($urandom, pick_key());
        repeat (3) add_push($urandom, pick_key());
        // A rejected push still abandons the walk.
        add_req(REQ_WALK, $urandom, $urandom);
        add_push($urandom, pick_key());
        add_req(REQ_KEEP, $urandom, $urandom);
        add_walk(CAPACITY, REQ_KEEP);
        add_walk(CAPACITY - 1, REQ_REMOVE);
        add_pause();
      end else if (sel < ((plan_held > 48) ? 15 : 45)) begin
        repeat ($urandom_range(1, 3)) add_push($urandom, pick_key());
      end else if (sel < 85) begin
        if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, plan_held);
        else steps = $urandom_range(0, (plan_held < 4) ? plan_held : 4);
        case ($urandom_range(0, 9))
          0, 1, 2:  add_walk(steps, REQ_KEEP);
          default:  add_walk(steps, REQ_REMOVE);
        endcase
      end else if (sel < 93) begin
        // Broken sequences: a walk cut short by a push or a new walk, or a stray reply.
        add_req(REQ_WALK, $urandom, $urandom);
        if ($urandom_range(0, 1) == 1) add_req(REQ_CONTINUE, $urandom, $urandom);
        case ($urandom_range(0, 2))
          0:       add_push($urandom, pick_key());
          1:       add_req(REQ_WALK, $urandom, $urandom);
          default: begin
            add_req(REQ_KEEP, $urandom, $urandom);
            add_req(3'($urandom_range(2, 4)), $urandom, $urandom);
          end
        endcase
      end else begin
        add_req(3'($urandom_range(2, 7)), $urandom, $urandom);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || req_bus.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ofpq_pkg.sv
design/ofpq_if.sv
design/ofpq_ctrl.sv
design/ofpq_dp.sv
design/ordered_fifo_priority_queue.sv
bench/ordered_fifo_priority_queue_tb.sv
